/* hw/rtl/mrc_pkg.sv */
`default_nettype none
package mrc_pkg;

    // input opcodes
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_CRC_ERR   = 3'd2;
    localparam logic [2:0] ST_EXCEPTION = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_SLAVE = 2'd0;
    localparam logic [1:0] CFG_READ_FUNCTION  = 2'd1;
    localparam logic [1:0] CFG_REGISTER_COUNT = 2'd2;
    localparam logic [1:0] CFG_WRITE_MODE     = 2'd3;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;
    localparam logic [7:0]  FUNC_WRITE    = 8'h06;
    localparam logic [6:0]  MAX_REGISTERS = 7'd125;

    typedef struct packed {
        logic [7:0] expected_slave;
        logic [6:0] read_function;
        logic [6:0] register_count;
        logic       write_mode;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [6:0] reg_index;
        logic [15:0] reg_value;
        logic [2:0] status;
        logic [7:0] exc_byte;
        logic       last;
    } t_result;

    // one byte step of the reflected crc-16
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/mrc_parser.sv */
`default_nettype none
module mrc_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [1:0]      i_op,
    input  wire logic [7:0]      i_byte,
    input  wire mrc_pkg::t_cfg   i_cfg,
    output mrc_pkg::t_result     o_result
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_FUNC  = 3'd2;
    localparam logic [2:0] PH_EXC   = 3'd3;
    localparam logic [2:0] PH_COUNT = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CRCLO = 3'd6;
    localparam logic [2:0] PH_CRCHI = 3'd7;

    logic [2:0]  r_phase,     n_phase;
    logic [15:0] r_crc,       n_crc;
    logic [7:0]  r_byte_pos,  n_byte_pos;
    logic [7:0]  r_high,      n_high;
    logic [7:0]  r_exc,       n_exc;
    logic [7:0]  r_crc_lo,    n_crc_lo;
    logic [6:0]  r_word_idx,  n_word_idx;
    logic        r_exc_reply, n_exc_reply;

    logic [7:0]  func;
    logic [7:0]  data_len;
    logic [15:0] crc_upd;
    logic [7:0]  pos_inc;
    logic [15:0] crc_got;
    mrc_pkg::t_result res;

    assign func     = i_cfg.write_mode ? mrc_pkg::FUNC_WRITE : {1'b0, i_cfg.read_function};
    assign data_len = i_cfg.write_mode ? 8'd4 : {i_cfg.register_count, 1'b0};
    assign crc_upd  = mrc_pkg::crc_step(r_crc, i_byte);
    assign pos_inc  = r_byte_pos + 8'd1;
    assign crc_got  = {i_byte, r_crc_lo};

    // next state and result for one item
    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_byte_pos  = r_byte_pos;
        n_high      = r_high;
        n_exc       = r_exc;
        n_crc_lo    = r_crc_lo;
        n_word_idx  = r_word_idx;
        n_exc_reply = r_exc_reply;
        res         = '0;

        priority if (i_op == mrc_pkg::OP_START) begin
            n_phase     = PH_ADDR;
            n_crc       = mrc_pkg::CRC_INIT;
            n_byte_pos  = '0;
            n_high      = '0;
            n_exc       = '0;
            n_crc_lo    = '0;
            n_word_idx  = '0;
            n_exc_reply = 1'b0;
        end else if (i_op == mrc_pkg::OP_TIMEOUT) begin
            if (r_phase != PH_IDLE) begin
                res.valid  = 1'b1;
                res.kind   = mrc_pkg::KIND_STATUS;
                res.status = mrc_pkg::ST_TIMEOUT;
                res.last   = 1'b1;
                n_phase    = PH_IDLE;
            end
        end else if (i_op == mrc_pkg::OP_BYTE) begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_ADDR: begin
                    if (i_byte != i_cfg.expected_slave) begin
                        res.valid  = 1'b1;
                        res.kind   = mrc_pkg::KIND_STATUS;
                        res.status = mrc_pkg::ST_INVALID;
                        res.last   = 1'b1;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_crc   = crc_upd;
                        n_phase = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    n_crc = crc_upd;
                    priority if (i_byte == (func | mrc_pkg::EXC_FLAG)) begin
                        n_exc_reply = 1'b1;
                        n_phase     = PH_EXC;
                    end else if (i_byte != func) begin
                        res.valid  = 1'b1;
                        res.kind   = mrc_pkg::KIND_STATUS;
                        res.status = mrc_pkg::ST_INVALID;
                        res.last   = 1'b1;
                        n_phase    = PH_IDLE;
                    end else if (i_cfg.write_mode) begin
                        n_byte_pos = '0;
                        n_phase    = PH_DATA;
                    end else begin
                        n_phase = PH_COUNT;
                    end
                end
                PH_EXC: begin
                    n_crc   = crc_upd;
                    n_exc   = i_byte;
                    n_phase = PH_CRCLO;
                end
                PH_COUNT: begin
                    if (i_cfg.register_count == 7'd0
                            || i_cfg.register_count > mrc_pkg::MAX_REGISTERS
                            || i_byte != data_len) begin
                        res.valid  = 1'b1;
                        res.kind   = mrc_pkg::KIND_STATUS;
                        res.status = mrc_pkg::ST_INVALID;
                        res.last   = 1'b1;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_crc      = crc_upd;
                        n_byte_pos = '0;
                        n_word_idx = '0;
                        n_phase    = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_crc      = crc_upd;
                    n_byte_pos = pos_inc;
                    if (!r_byte_pos[0]) begin
                        n_high = i_byte;
                    end else if (!i_cfg.write_mode) begin
                        // low byte completes a register word
                        res.valid     = 1'b1;
                        res.kind      = mrc_pkg::KIND_WORD;
                        res.reg_index = r_word_idx;
                        res.reg_value = {r_high, i_byte};
                        n_word_idx    = r_word_idx + 7'd1;
                    end
                    if (pos_inc >= data_len) begin
                        n_phase = PH_CRCLO;
                    end
                end
                PH_CRCLO: begin
                    n_crc_lo = i_byte;
                    n_phase  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    res.valid = 1'b1;
                    res.kind  = mrc_pkg::KIND_STATUS;
                    res.last  = 1'b1;
                    n_phase   = PH_IDLE;
                    priority if (crc_got != r_crc) begin
                        res.status = mrc_pkg::ST_CRC_ERR;
                    end else if (r_exc_reply) begin
                        res.status   = mrc_pkg::ST_EXCEPTION;
                        res.exc_byte = r_exc;
                    end else begin
                        res.status = mrc_pkg::ST_OK;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            // unused opcode leaves everything as is
        end
    end

    // reply state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_crc       <= mrc_pkg::CRC_INIT;
            r_byte_pos  <= '0;
            r_high      <= '0;
            r_exc       <= '0;
            r_crc_lo    <= '0;
            r_word_idx  <= '0;
            r_exc_reply <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_crc       <= n_crc;
            r_byte_pos  <= n_byte_pos;
            r_high      <= n_high;
            r_exc       <= n_exc;
            r_crc_lo    <= n_crc_lo;
            r_word_idx  <= n_word_idx;
            r_exc_reply <= n_exc_reply;
        end
    end

    assign o_result = res;

endmodule
`default_nettype wire

/* hw/rtl/mrc_out_stage.sv */
`default_nettype none
module mrc_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire mrc_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_open,
    output mrc_pkg::t_result      o_result
);

    logic             r_valid;
    mrc_pkg::t_result r_data;

    // room for a new result when empty or the held one leaves this cycle
    assign o_open = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_open) begin
            r_valid <= i_step && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_open && i_step && i_result.valid) begin
            r_data <= i_result;
        end
    end

    always_comb begin
        o_result       = r_data;
        o_result.valid = r_valid;
    end

endmodule
`default_nettype wire

/* hw/rtl/modbus_rtu_response_checker.sv */
`default_nettype none
// an item is registered at the input, then its result is registered in the output stage
// throughput: one item per cycle while the output stage has room; the combinational crc byte step sets the clock path
// a result waiting at the output does not block the next input transfer unless both stall
// reset (synchronous, active low) empties both registers, idles the parser and loads
// register defaults: slave 1, read function 3, register count 1, read mode
module modbus_rtu_response_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // reg_index[6:0], reg_value[22:7],
                                             // status[25:23], exc_byte[33:26], zero
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast
);

    mrc_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    logic [1:0]       r_in_op;
    logic [7:0]       r_in_byte;
    logic             step;
    logic             out_open;
    mrc_pkg::t_result parse_res;
    mrc_pkg::t_result out_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_slave <= 8'd1;
            r_cfg.read_function  <= 7'd3;
            r_cfg.register_count <= 7'd1;
            r_cfg.write_mode     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mrc_pkg::CFG_EXPECTED_SLAVE: r_cfg.expected_slave <= i_cfg_data;
                mrc_pkg::CFG_READ_FUNCTION:  r_cfg.read_function  <= i_cfg_data[6:0];
                mrc_pkg::CFG_REGISTER_COUNT: r_cfg.register_count <= i_cfg_data[6:0];
                mrc_pkg::CFG_WRITE_MODE:     r_cfg.write_mode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input register, drained whenever the output stage has room
    assign step          = r_in_valid && out_open;
    assign s_axis_tready = !r_in_valid || out_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    mrc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_op     (r_in_op),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (parse_res)
    );

    mrc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_result (parse_res),
        .i_ready  (m_axis_tready),
        .o_open   (out_open),
        .o_result (out_res)
    );

    // result packing
    assign m_axis_tvalid = out_res.valid;
    assign m_axis_tuser  = out_res.kind;
    assign m_axis_tlast  = out_res.last;
    assign m_axis_tdata  = {6'd0, out_res.exc_byte, out_res.status,
                            out_res.reg_value, out_res.reg_index};

endmodule
`default_nettype wire

/* dv/tb_modbus_rtu_response_checker.sv */
`timescale 1ns / 1ps
module tb_modbus_rtu_response_checker;
    import mrc_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 900;
    // opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE, PH_ADDR, PH_FUNC, PH_EXC, PH_COUNT, PH_DATA, PH_CRC_LO, PH_CRC_HI
    } t_parse_phase;

    typedef enum int {
        RP_GOOD, RP_EXCEPTION, RP_BAD_CRC, RP_BAD_ADDR, RP_BAD_FUNC, RP_BAD_COUNT,
        RP_TIMEOUT, RP_RESTART
    } t_reply_flavor;

    typedef struct packed {
        logic        kind;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        logic [2:0]  status;
        logic [7:0]  exc_byte;
        logic        last;
    } t_reply;

    typedef struct {
        bit         is_cfg;
        logic [1:0] op;
        logic [7:0] rx;
        logic [1:0] reg_idx;
        logic [7:0] wdata;
    } t_bus_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    t_bus_cmd    pending_cmds[$];
    t_reply      expected_replies[$];
    logic [7:0]  frame_q[$];
    int          reply_items = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          since_item = 0;

    // stimulus-side copy of the settings, used to build replies
    logic [7:0]  plan_slave = 8'd1;
    logic [6:0]  plan_func = 7'd3;
    logic [6:0]  plan_count = 7'd1;
    logic        plan_write = 1'b0;

    // parser prediction: settings and reply state
    logic [7:0]   prs_slave;
    logic [6:0]   prs_func;
    logic [6:0]   prs_count;
    logic         prs_write;
    t_parse_phase prs_phase;
    logic [15:0]  prs_crc;
    logic [7:0]   prs_pos;
    logic [7:0]   prs_hold;
    logic [7:0]   prs_exc_code;
    logic [7:0]   prs_crc_lo;
    logic [6:0]   prs_word;
    logic         prs_is_exc;

    modbus_rtu_response_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bit-serial reflected crc-16, one byte
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int k = 0; k < 8; k++) begin
            fb = acc[0] ^ b[k];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // random idling, switched off in every fourth window of the run
    function automatic bit take_break();
        if ((cycle_count / 500) % 4 == 2) begin
            return 1'b0;
        end
        return $urandom_range(99) < 15;
    endfunction

    function automatic string fmt_reply(input t_reply r);
        return $sformatf("kind=%0d index=%0d value=%04h status=%0d exc=%02h last=%0d",
                         r.kind, r.reg_index, r.reg_value, r.status, r.exc_byte, r.last);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------
    function automatic void clear_reply_state();
        prs_crc = CRC_INIT;
        prs_pos = 8'd0;
        prs_hold = 8'd0;
        prs_exc_code = 8'd0;
        prs_crc_lo = 8'd0;
        prs_word = 7'd0;
        prs_is_exc = 1'b0;
    endfunction

    function automatic bit close_reply(output t_reply r, input logic [2:0] st,
                                       input logic [7:0] code);
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        r.exc_byte = code;
        r.last = 1'b1;
        prs_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // one input transfer; returns 1 when it produces a result
    function automatic bit predict_item(input logic [1:0] op, input logic [7:0] b,
                                        output t_reply r);
        logic [7:0]  fcode;
        int unsigned dlen;
        bit          hit;
        fcode = prs_write ? FUNC_WRITE : {1'b0, prs_func};
        dlen = prs_write ? 4 : 2 * prs_count;
        r = '0;
        hit = 1'b0;
        if (op == OP_START) begin
            clear_reply_state();
            prs_phase = PH_ADDR;
        end else if (op == OP_TIMEOUT) begin
            if (prs_phase != PH_IDLE) begin
                hit = close_reply(r, ST_TIMEOUT, 8'h00);
            end
        end else if (op == OP_BYTE && prs_phase != PH_IDLE) begin
            case (prs_phase)
                PH_ADDR: begin
                    if (b != prs_slave) begin
                        hit = close_reply(r, ST_INVALID, 8'h00);
                    end else begin
                        prs_crc = crc16_update(prs_crc, b);
                        prs_phase = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    prs_crc = crc16_update(prs_crc, b);
                    if (b == (fcode | EXC_FLAG)) begin
                        prs_is_exc = 1'b1;
                        prs_phase = PH_EXC;
                    end else if (b != fcode) begin
                        hit = close_reply(r, ST_INVALID, 8'h00);
                    end else if (prs_write) begin
                        prs_pos = 8'd0;
                        prs_phase = PH_DATA;
                    end else begin
                        prs_phase = PH_COUNT;
                    end
                end
                PH_EXC: begin
                    prs_crc = crc16_update(prs_crc, b);
                    prs_exc_code = b;
                    prs_phase = PH_CRC_LO;
                end
                PH_COUNT: begin
                    if (prs_count == 7'd0 || prs_count > MAX_REGISTERS || b != dlen) begin
                        hit = close_reply(r, ST_INVALID, 8'h00);
                    end else begin
                        prs_crc = crc16_update(prs_crc, b);
                        prs_pos = 8'd0;
                        prs_word = 7'd0;
                        prs_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    prs_crc = crc16_update(prs_crc, b);
                    if (!prs_pos[0]) begin
                        prs_hold = b;
                    end else if (!prs_write) begin
                        r.kind = KIND_WORD;
                        r.reg_index = prs_word;
                        r.reg_value = {prs_hold, b};
                        prs_word = prs_word + 7'd1;
                        hit = 1'b1;
                    end
                    prs_pos = prs_pos + 8'd1;
                    if (prs_pos >= dlen) begin
                        prs_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    prs_crc_lo = b;
                    prs_phase = PH_CRC_HI;
                end
                default: begin
                    if ({b, prs_crc_lo} != prs_crc) begin
                        hit = close_reply(r, ST_CRC_ERR, 8'h00);
                    end else if (prs_is_exc) begin
                        hit = close_reply(r, ST_EXCEPTION, prs_exc_code);
                    end else begin
                        hit = close_reply(r, ST_OK, 8'h00);
                    end
                end
            endcase
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] op, input logic [7:0] b);
        t_bus_cmd c;
        c.is_cfg = 1'b0;
        c.op = op;
        c.rx = b;
        c.reg_idx = CFG_EXPECTED_SLAVE;
        c.wdata = 8'd0;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic push_cfg(input logic [1:0] idx, input logic [7:0] d);
        t_bus_cmd c;
        c.is_cfg = 1'b1;
        c.op = OP_BYTE;
        c.rx = 8'd0;
        c.reg_idx = idx;
        c.wdata = d;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // write every register; unused upper data bits get random values
    task automatic set_config(input logic [7:0] slave, input logic [6:0] func,
                              input logic [6:0] count, input logic wmode);
        push_cfg(CFG_EXPECTED_SLAVE, slave);
        push_cfg(CFG_READ_FUNCTION, {1'($urandom_range(1)), func});
        push_cfg(CFG_REGISTER_COUNT, {1'($urandom_range(1)), count});
        push_cfg(CFG_WRITE_MODE, {7'($urandom_range(127)), wmode});
        plan_slave = slave;
        plan_func = func;
        plan_count = count;
        plan_write = wmode;
    endtask

    task automatic seal_frame();
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (frame_q[i]) begin
            crc = crc16_update(crc, frame_q[i]);
        end
        frame_q.insert(frame_q.size(), crc[7:0]);
        frame_q.insert(frame_q.size(), crc[15:8]);
    endtask

    // start transfer followed by the frame bytes
    task automatic send_frame();
        push_item(OP_START, 8'($urandom_range(255)));
        foreach (frame_q[i]) begin
            push_item(OP_BYTE, frame_q[i]);
        end
        reply_items += frame_q.size() + 1;
    endtask

    task automatic push_reply(input t_reply_flavor fl);
        logic [7:0] fcode;
        logic [7:0] x;
        int         dlen;
        int         keep;
        int         pos;
        fcode = plan_write ? FUNC_WRITE : {1'b0, plan_func};
        dlen = plan_write ? 4 : 2 * plan_count;
        frame_q.delete();
        x = plan_slave;
        if (fl == RP_BAD_ADDR) begin
            do x = 8'($urandom_range(255)); while (x == plan_slave);
        end
        frame_q.insert(frame_q.size(), x);
        if (fl == RP_EXCEPTION) begin
            frame_q.insert(frame_q.size(), fcode | EXC_FLAG);
            frame_q.insert(frame_q.size(), 8'($urandom_range(255)));
        end else begin
            x = fcode;
            if (fl == RP_BAD_FUNC) begin
                do x = 8'($urandom_range(255)); while (x == fcode || x == (fcode | EXC_FLAG));
            end
            frame_q.insert(frame_q.size(), x);
            if (!plan_write) begin
                x = 8'(dlen);
                if (fl == RP_BAD_COUNT) begin
                    do x = 8'($urandom_range(255)); while (x == 8'(dlen));
                end
                frame_q.insert(frame_q.size(), x);
            end
            repeat (dlen) frame_q.insert(frame_q.size(), 8'($urandom_range(255)));
        end
        seal_frame();
        // corrupt one bit past the function code
        if (fl == RP_BAD_CRC) begin
            pos = $urandom_range(frame_q.size() - 1, 2);
            frame_q[pos] = frame_q[pos] ^ (8'd1 << $urandom_range(7));
        end
        // cut the frame short
        if (fl == RP_TIMEOUT || fl == RP_RESTART) begin
            keep = $urandom_range(frame_q.size() - 1);
            while (frame_q.size() > keep) frame_q.pop_back();
        end
        send_frame();
        if (fl == RP_TIMEOUT) begin
            push_item(OP_TIMEOUT, 8'($urandom_range(255)));
            reply_items++;
        end
    endtask

    // replies with random flavors and a little noise in between
    task automatic run_phase(input int budget);
        int            base;
        int            pick;
        t_reply_flavor fl;
        base = reply_items;
        while (reply_items - base < budget) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(3, 1)) begin
                    push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
                end
            end
            pick = $urandom_range(99);
            if (pick < 45)      fl = RP_GOOD;
            else if (pick < 55) fl = RP_EXCEPTION;
            else if (pick < 67) fl = RP_BAD_CRC;
            else if (pick < 73) fl = RP_BAD_ADDR;
            else if (pick < 79) fl = RP_BAD_FUNC;
            else if (pick < 84) fl = RP_BAD_COUNT;
            else if (pick < 92) fl = RP_TIMEOUT;
            else                fl = RP_RESTART;
            push_reply(fl);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: input and configuration transfers, result back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bus_cmd cmd;
        bit       s_done;
        bit       c_done;
        bit       s_next;
        bit       c_next;
        if (i_rst_n) begin
            s_done = s_axis_tvalid && s_axis_tready;
            c_done = i_cfg_valid && o_cfg_ready;
            s_next = s_axis_tvalid && !s_done;
            c_next = i_cfg_valid && !c_done;
            if (!s_next && !c_next && pending_cmds.size() != 0) begin
                if (!pending_cmds[0].is_cfg) begin
                    if (!take_break()) begin
                        cmd = pending_cmds.pop_front();
                        s_axis_tdata <= cmd.rx;
                        s_axis_tuser <= cmd.op;
                        s_next = 1'b1;
                    end
                end else if (!s_done && since_item >= SETTLE_CYCLES &&
                             expected_replies.size() == 0) begin
                    // register writes only once the parser has gone quiet
                    cmd = pending_cmds.pop_front();
                    i_cfg_index <= cmd.reg_idx;
                    i_cfg_data <= cmd.wdata;
                    c_next = 1'b1;
                end
            end
            s_axis_tvalid <= s_next;
            i_cfg_valid <= c_next;
            m_axis_tready <= !take_break();
            if (s_done) begin
                since_item <= 0;
            end else if (since_item < SETTLE_CYCLES) begin
                since_item <= since_item + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: prediction on accepted inputs, check of accepted results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        t_reply pred;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (!i_rst_n) begin
            prs_slave = 8'd1;
            prs_func = 7'd3;
            prs_count = 7'd1;
            prs_write = 1'b0;
            prs_phase = PH_IDLE;
            clear_reply_state();
            expected_replies.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.reg_index = m_axis_tdata[6:0];
                got.reg_value = m_axis_tdata[22:7];
                got.status = m_axis_tdata[25:23];
                got.exc_byte = m_axis_tdata[33:26];
                got.last = m_axis_tlast;
                if (expected_replies.size() == 0) begin
                    note_error($sformatf("unexpected result %s", fmt_reply(got)));
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want) begin
                        note_error($sformatf("expected %s, got %s",
                                             fmt_reply(want), fmt_reply(got)));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EXPECTED_SLAVE: prs_slave = i_cfg_data;
                    CFG_READ_FUNCTION:  prs_func = i_cfg_data[6:0];
                    CFG_REGISTER_COUNT: prs_count = i_cfg_data[6:0];
                    default:            prs_write = i_cfg_data[0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (predict_item(s_axis_tuser, s_axis_tdata, pred)) begin
                    expected_replies.insert(expected_replies.size(), pred);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int         base;
        int         pick;
        logic [6:0] count;

        // directed, with the reset settings
        push_item(OP_BYTE, 8'hFF);      // byte while idle
        push_item(OP_TIMEOUT, 8'h00);   // timeout while idle
        push_item(OP_UNUSED, 8'hFF);    // unused opcode
        frame_q = '{8'h01, 8'h03, 8'h02, 8'hFF, 8'h00};
        seal_frame();
        send_frame();
        frame_q = '{8'h01, 8'h83, 8'hFF};
        seal_frame();
        send_frame();
        frame_q = '{8'h00};             // wrong address
        send_frame();
        frame_q = '{8'h01, 8'h7F};      // wrong function
        send_frame();
        frame_q = '{8'h01, 8'h03, 8'h00};   // wrong byte count
        send_frame();
        push_item(OP_START, 8'h00);     // timeout right after start
        push_item(OP_TIMEOUT, 8'hFF);

        // corner settings
        base = reply_items;
        set_config(8'h00, 7'h00, 7'd1, 1'b0);
        run_phase(60);
        set_config(8'hFF, 7'h7F, MAX_REGISTERS, 1'b0);
        push_reply(RP_GOOD);
        set_config(8'h5A, 7'h03, 7'd3, 1'b1);
        run_phase(60);
        set_config(8'($urandom_range(255)), 7'h04, 7'd0, 1'b0);
        run_phase(15);
        set_config(8'($urandom_range(255)), 7'h03, 7'd127, 1'b0);
        run_phase(15);

        // random settings, mostly small register counts
        while (reply_items - base < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 80)      count = 7'($urandom_range(4, 1));
            else if (pick < 95) count = 7'($urandom_range(16, 5));
            else if (pick < 97) count = 7'd0;
            else                count = 7'($urandom_range(127, 126));
            set_config(8'($urandom_range(255)),
                       $urandom_range(1) ? 7'($urandom_range(4, 3)) : 7'($urandom_range(127)),
                       count, $urandom_range(99) < 30);
            run_phase(60);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every transfer and every expected result
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || i_cfg_valid ||
               expected_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* modbus_rtu_response_checker.f */
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_parser.sv
hw/rtl/mrc_out_stage.sv
hw/rtl/modbus_rtu_response_checker.sv
dv/tb_modbus_rtu_response_checker.sv
